// ===== design/bee_pkg.sv =====
// ----------------------------------------------------------------------------
// bee_pkg
// Shared constants for the byte entropy estimator: fixed-point formats of the
// logarithm and the result, histogram geometry and output field widths.
// ----------------------------------------------------------------------------
package bee_pkg;

  // Number of histogram bins and the width of a bin index.
  localparam int unsigned BIN_COUNT = 256;
  localparam int unsigned BIN_W     = 8;

  // Fraction bits of log2 values and of the reported entropy.
  localparam int unsigned LOG_FRAC  = 28;
  localparam int unsigned FRAC_BITS = 16;

  // Normalized mantissa of the log unit, Q1.31.
  localparam int unsigned MANT_W    = 32;

  // Output field widths.
  localparam int unsigned ENT_W     = 20;
  localparam int unsigned COUNT_W   = 17;

  // Largest entropy value, 8.0 bits per byte.
  localparam int unsigned ENT_MAX   = 8 << FRAC_BITS;

endpackage

// ===== design/byte_entropy_estimator.sv =====
// ----------------------------------------------------------------------------
// byte_entropy_estimator
// Shannon entropy of a byte buffer in bits per byte, unsigned Q4.16.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while the input is not stalled; in_stall_o is
//   high outside the run state. Each byte is a histogram read-modify-write with
//   forwarding from the previous write of the same bin.
// After the last byte, the block reads all 256 bins, runs log and accumulate
//   for each nonzero bin, then log2 of the length and the serial divider.
// Reset: a clearing pass zeroes all 256 bins of the histogram; no byte is
//   taken until it ends. Each result sweep also clears the histogram.
// ----------------------------------------------------------------------------
module byte_entropy_estimator #(
  parameter int unsigned MAX_BYTES = 65536
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   byte_value_i,
  input  logic                         last_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [bee_pkg::ENT_W-1:0]    entropy_bits_o,
  output logic [bee_pkg::COUNT_W-1:0]  byte_count_o,
  output logic                         overflowed_o
);

  localparam int unsigned CNT_W   = $clog2(MAX_BYTES + 1);
  localparam int unsigned LOG_W   = $clog2(CNT_W) + bee_pkg::LOG_FRAC;
  localparam int unsigned PROD_W  = CNT_W + LOG_W;
  localparam int unsigned DEN_SH  = bee_pkg::LOG_FRAC - bee_pkg::FRAC_BITS;
  localparam int unsigned DEN_W   = CNT_W + DEN_SH;
  localparam int unsigned DVD_W   = PROD_W + 1;
  localparam int unsigned DSTEP_W = $clog2(DVD_W + 1);
  localparam int unsigned BW      = bee_pkg::BIN_W;

  // Controller states.
  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_RUN   = 4'd1;
  localparam logic [3:0] ST_DRAIN = 4'd2;
  localparam logic [3:0] ST_SREAD = 4'd3;
  localparam logic [3:0] ST_SWAIT = 4'd4;
  localparam logic [3:0] ST_SLOG  = 4'd5;
  localparam logic [3:0] ST_SACC  = 4'd6;
  localparam logic [3:0] ST_NLOG  = 4'd7;
  localparam logic [3:0] ST_NWAIT = 4'd8;
  localparam logic [3:0] ST_NSUB  = 4'd9;
  localparam logic [3:0] ST_DIV   = 4'd10;
  localparam logic [3:0] ST_OUT   = 4'd11;

  logic [3:0]         state_q, state_d;
  logic [BW-1:0]      idx_q, idx_d;
  logic [CNT_W-1:0]   len_q, len_d;
  logic               ovf_q, ovf_d;

  // Increment stage of the byte path.
  logic               p_valid_q, p_valid_d;
  logic [BW-1:0]      p_addr_q;
  logic               hit_q, hit_d;
  logic [CNT_W-1:0]   fwd_q;

  // Sweep and arithmetic registers.
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [PROD_W-1:0]  prod_q, prod_d;
  logic [PROD_W-1:0]  acc_q, acc_d;
  logic [DVD_W-1:0]   dvd_q, dvd_d;
  logic [DEN_W-1:0]   rem_q, rem_d;
  logic [DSTEP_W-1:0] dstep_q, dstep_d;

  // Result register.
  logic                        out_valid_q, out_valid_d;
  logic [bee_pkg::ENT_W-1:0]   ent_q, ent_d;
  logic [bee_pkg::COUNT_W-1:0] cntout_q, cntout_d;
  logic                        ovfout_q, ovfout_d;

  logic               in_acc;
  logic               counted;
  logic [BW-1:0]      ram_raddr;
  logic               ram_we;
  logic [BW-1:0]      ram_waddr;
  logic [CNT_W-1:0]   ram_wdata;
  logic [CNT_W-1:0]   ram_rdata;
  logic [CNT_W-1:0]   old_cnt;
  logic [CNT_W-1:0]   inc_cnt;

  logic               log_start;
  logic [CNT_W-1:0]   log_x;
  logic               log_busy;
  logic               log_done;
  logic [LOG_W-1:0]   log_val;

  logic [DEN_W-1:0]   den;
  logic [DEN_W:0]     trial;
  logic               trial_ge;
  logic [DVD_W-1:0]   clamped;

  // Histogram memory.
  bee_ram #(
    .WIDTH (CNT_W),
    .DEPTH (bee_pkg::BIN_COUNT)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Shared logarithm unit for bin counts and the buffer length.
  bee_log2 #(
    .XW (CNT_W)
  ) u_log2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (log_start),
    .x_i     (log_x),
    .busy_o  (log_busy),
    .done_o  (log_done),
    .log_o   (log_val)
  );

  // Input handshake and the count/overflow decision for the arriving byte.
  assign in_stall_o = (state_q != ST_RUN);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign counted    = in_acc && (len_q < CNT_W'(MAX_BYTES));

  // Bin value seen by the increment stage, forwarded past the last write.
  assign old_cnt = hit_q ? fwd_q : ram_rdata;
  assign inc_cnt = old_cnt + CNT_W'(1);

  // Memory ports: increments first, then the zeroing writes of the sweeps.
  always_comb begin
    ram_raddr = (state_q == ST_RUN) ? byte_value_i : idx_q;
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = '0;
    if (p_valid_q) begin
      ram_we    = 1'b1;
      ram_waddr = p_addr_q;
      ram_wdata = inc_cnt;
    end else if (state_q == ST_CLEAR || state_q == ST_SREAD) begin
      ram_we = 1'b1;
    end
  end

  // Log operand and start.
  assign log_x     = (state_q == ST_NLOG) ? len_q : ram_rdata;
  assign log_start = (state_q == ST_NLOG) ||
                     (state_q == ST_SWAIT && ram_rdata != '0);

  // Restoring division step and result clamp.
  assign den      = DEN_W'(len_q) << DEN_SH;
  assign trial    = {rem_q, dvd_q[DVD_W-1]};
  assign trial_ge = (trial >= {1'b0, den});
  assign clamped  = (dvd_q > DVD_W'(bee_pkg::ENT_MAX)) ? DVD_W'(bee_pkg::ENT_MAX) : dvd_q;

  // Controller.
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    len_d       = len_q;
    ovf_d       = ovf_q;
    p_valid_d   = counted;
    hit_d       = counted && p_valid_q && (p_addr_q == byte_value_i);
    cnt_d       = cnt_q;
    prod_d      = prod_q;
    acc_d       = acc_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    dstep_d     = dstep_q;
    out_valid_d = out_valid_q && out_stall_i;
    ent_d       = ent_q;
    cntout_d    = cntout_q;
    ovfout_d    = ovfout_q;

    unique case (state_q)
      ST_CLEAR: begin
        idx_d = idx_q + BW'(1);
        if (idx_q == '1) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (in_acc) begin
          if (counted) begin
            len_d = len_q + CNT_W'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (last_byte_i) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        idx_d   = '0;
        acc_d   = '0;
        state_d = ST_SREAD;
      end
      ST_SREAD: begin
        state_d = ST_SWAIT;
      end
      ST_SWAIT: begin
        cnt_d = ram_rdata;
        if (ram_rdata != '0) begin
          state_d = ST_SLOG;
        end else if (idx_q == '1) begin
          state_d = ST_NLOG;
        end else begin
          idx_d   = idx_q + BW'(1);
          state_d = ST_SREAD;
        end
      end
      ST_SLOG: begin
        if (log_done) begin
          prod_d  = PROD_W'(cnt_q) * PROD_W'(log_val);
          state_d = ST_SACC;
        end
      end
      ST_SACC: begin
        acc_d = acc_q + prod_q;
        if (idx_q == '1) begin
          state_d = ST_NLOG;
        end else begin
          idx_d   = idx_q + BW'(1);
          state_d = ST_SREAD;
        end
      end
      ST_NLOG: begin
        state_d = ST_NWAIT;
      end
      ST_NWAIT: begin
        if (log_done) begin
          prod_d  = PROD_W'(len_q) * PROD_W'(log_val);
          state_d = ST_NSUB;
        end
      end
      ST_NSUB: begin
        // Numerator plus half the divisor gives round-half-up.
        dvd_d   = ((prod_q > acc_q) ? DVD_W'(prod_q - acc_q) : '0) +
                  (DVD_W'(len_q) << (DEN_SH - 1));
        rem_d   = '0;
        dstep_d = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        rem_d   = trial_ge ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
        dvd_d   = {dvd_q[DVD_W-2:0], trial_ge};
        dstep_d = dstep_q + DSTEP_W'(1);
        if (dstep_q == DSTEP_W'(DVD_W - 1)) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q) begin
          out_valid_d = 1'b1;
          ent_d       = bee_pkg::ENT_W'(clamped);
          cntout_d    = bee_pkg::COUNT_W'(len_q);
          ovfout_d    = ovf_q;
          len_d       = '0;
          ovf_d       = 1'b0;
          state_d     = ST_RUN;
        end
      end
      default: begin
        state_d = ST_CLEAR;
        idx_d   = '0;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      idx_q       <= '0;
      len_q       <= '0;
      ovf_q       <= 1'b0;
      p_valid_q   <= 1'b0;
      hit_q       <= 1'b0;
      dstep_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      len_q       <= len_d;
      ovf_q       <= ovf_d;
      p_valid_q   <= p_valid_d;
      hit_q       <= hit_d;
      dstep_q     <= dstep_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    p_addr_q <= byte_value_i;
    fwd_q    <= inc_cnt;
    cnt_q    <= cnt_d;
    prod_q   <= prod_d;
    acc_q    <= acc_d;
    dvd_q    <= dvd_d;
    rem_q    <= rem_d;
    ent_q    <= ent_d;
    cntout_q <= cntout_d;
    ovfout_q <= ovfout_d;
  end

  assign out_valid_o    = out_valid_q;
  assign entropy_bits_o = ent_q;
  assign byte_count_o   = cntout_q;
  assign overflowed_o   = ovfout_q;

`ifndef ASSERT_OFF
  // The length counter never runs past the configured maximum.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= CNT_W'(MAX_BYTES))
    else $error("length counter exceeds maximum");

  // Increments only happen while bytes stream in or drain.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_valid_q |-> (state_q == ST_RUN || state_q == ST_DRAIN))
    else $error("histogram increment outside the byte phase");

  // The log unit is never restarted while it works.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    log_start |-> !log_busy)
    else $error("log unit started while busy");

  // A result is only loaded for a buffer that counted at least one byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && !out_valid_q) |-> (len_q != '0))
    else $error("result for an empty buffer");
`endif

endmodule

// ===== design/bee_ram.sv =====
// ----------------------------------------------------------------------------
// bee_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data. A read of the address being written returns the old contents.
// ----------------------------------------------------------------------------
module bee_ram #(
  parameter int unsigned WIDTH = 17,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Storage write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/bee_log2.sv =====
// ----------------------------------------------------------------------------
// bee_log2
// Iterative base-2 logarithm. The integer part is the leading-one position;
// the fraction is found one bit per cycle by squaring the normalized mantissa.
// ----------------------------------------------------------------------------
module bee_log2 #(
  parameter int unsigned XW = 17
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    start_i,
  input  logic [XW-1:0]                           x_i,
  output logic                                    busy_o,
  output logic                                    done_o,
  output logic [$clog2(XW)+bee_pkg::LOG_FRAC-1:0] log_o
);

  localparam int unsigned PW = $clog2(XW);
  localparam int unsigned MW = bee_pkg::MANT_W;
  localparam int unsigned LF = bee_pkg::LOG_FRAC;

  logic [PW-1:0]   lead;
  logic [5:0]      norm_sh;
  logic [MW-1:0]   mant_init;
  logic [2*MW-1:0] prod;
  logic [MW:0]     sq;

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [4:0]      step_q, step_d;
  logic [MW-1:0]   mant_q, mant_d;
  logic [PW-1:0]   pos_q, pos_d;
  logic [LF-1:0]   frac_q, frac_d;

  // Leading-one position and normalization of the operand.
  always_comb begin
    lead = '0;
    for (int i = 0; i < XW; i++) begin
      if (x_i[i]) begin
        lead = PW'(i);
      end
    end
    norm_sh   = 6'(MW - 1) - 6'(lead);
    mant_init = MW'(x_i) << norm_sh;
  end

  // One squaring step; a carry into bit 32 yields a fraction bit of one.
  assign prod = (2*MW)'(mant_q) * (2*MW)'(mant_q);
  assign sq   = prod[2*MW-1:MW-1];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    mant_d = mant_q;
    pos_d  = pos_q;
    frac_d = frac_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      mant_d = mant_init;
      pos_d  = lead;
      frac_d = '0;
    end else if (busy_q) begin
      mant_d = sq[MW] ? sq[MW:1] : sq[MW-1:0];
      frac_d = {frac_q[LF-2:0], sq[MW]};
      step_d = step_q + 5'd1;
      if (step_q == 5'(LF - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    mant_q <= mant_d;
    pos_q  <= pos_d;
    frac_q <= frac_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign log_o  = {pos_q, frac_q};

endmodule

// ===== tb/byte_entropy_estimator_test.sv =====
// ----------------------------------------------------------------------------
// byte_entropy_estimator_test
// Feeds byte buffers of random and directed content into the entropy block
// and checks every reported entropy, byte count and overflow flag against an
// integer predictor kept in the testbench.
// ----------------------------------------------------------------------------
module byte_entropy_estimator_test;

  // Count limit of the block, its default.
  localparam int unsigned MAX_LEN = 65536;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } byte_word_t;

  typedef struct packed {
    logic [bee_pkg::ENT_W-1:0]   entropy;
    logic [bee_pkg::COUNT_W-1:0] count;
    logic                        ovf;
  } entropy_word_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  logic [7:0] byte_value_i;
  logic last_byte_i;
  logic out_valid_o;
  logic out_stall_i;
  logic [bee_pkg::ENT_W-1:0] entropy_bits_o;
  logic [bee_pkg::COUNT_W-1:0] byte_count_o;
  logic overflowed_o;

  byte_entropy_estimator #(.MAX_BYTES(MAX_LEN)) DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .byte_value_i, .last_byte_i,
    .out_valid_o, .out_stall_i, .entropy_bits_o, .byte_count_o, .overflowed_o
  );

  byte_word_t    pending_bytes[$];
  entropy_word_t expected_results[$];

  // Predictor state.
  int unsigned bin_counts[bee_pkg::BIN_COUNT];
  int unsigned bytes_seen;
  bit          too_long;

  int errors = 0;
  int buffers_done = 0;
  int overflow_buffers = 0;
  bit hold_req = 0;
  bit hold_taken = 0;
  int unsigned hold_left = 0;
  bit stim_done = 0;

  // Stall as sampled at the last rising edge decides acceptance there.
  logic in_stall_o_q;
  always @(posedge clk_i) in_stall_o_q <= in_stall_o;

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  // Fixed-point log2 with LOG_FRAC fraction bits, mantissa squared in Q1.31.
  function automatic logic [63:0] log2_q28(int unsigned x);
    int unsigned pos;
    logic [63:0] mant;
    logic [63:0] frac;
    pos = 0;
    frac = 0;
    if (x == 0) return 0;
    while (pos < 31 && (x >> (pos + 1)) != 0) pos++;
    mant = 64'(x) << (31 - pos);
    for (int i = 0; i < bee_pkg::LOG_FRAC; i++) begin
      mant = (mant * mant) >> 31;
      frac = frac << 1;
      if (mant >= (64'd1 << 32)) begin
        frac[0] = 1'b1;
        mant = mant >> 1;
      end
    end
    return (64'(pos) << bee_pkg::LOG_FRAC) | frac;
  endfunction

  // Count one accepted byte and queue a result when it closes the buffer.
  task automatic predict_entropy(byte_word_t w);
    logic [63:0] weighted, total, num, den, res;
    entropy_word_t r;
    weighted = 0;
    if (bytes_seen < MAX_LEN) begin
      bin_counts[w.value]++;
      bytes_seen++;
    end else begin
      too_long = 1;
    end
    if (w.last) begin
      for (int b = 0; b < bee_pkg::BIN_COUNT; b++)
        if (bin_counts[b] != 0) weighted += 64'(bin_counts[b]) * log2_q28(bin_counts[b]);
      total = 64'(bytes_seen) * log2_q28(bytes_seen);
      num = (total > weighted) ? total - weighted : 0;
      den = 64'(bytes_seen) << (bee_pkg::LOG_FRAC - bee_pkg::FRAC_BITS);
      res = (num + den / 2) / den;
      if (res > bee_pkg::ENT_MAX) res = bee_pkg::ENT_MAX;
      r.entropy = res[bee_pkg::ENT_W-1:0];
      r.count = bytes_seen[bee_pkg::COUNT_W-1:0];
      r.ovf = too_long;
      if (too_long) overflow_buffers++;
      expected_results.push_back(r);
      foreach (bin_counts[b]) bin_counts[b] = 0;
      bytes_seen = 0;
      too_long = 0;
    end
  endtask

  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Driver: presents queued words at the falling edge, honoring stall.
  int unsigned in_gap = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o_q) begin
        predict_entropy(pending_bytes.pop_front());
        in_gap = gap_len();
      end
      if (!(in_valid_i && in_stall_o_q)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 0;
        end else if (pending_bytes.size() > 0) begin
          in_valid_i <= 1;
          byte_value_i <= pending_bytes[0].value;
          last_byte_i <= pending_bytes[0].last;
        end else begin
          in_valid_i <= 0;
        end
      end
    end
  end

  // Monitor: checks results at the rising edge.
  int unsigned out_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result word: entropy %0d count %0d", entropy_bits_o, byte_count_o);
        errors++;
      end else begin
        entropy_word_t e;
        e = expected_results.pop_front();
        buffers_done++;
        if (entropy_bits_o !== e.entropy) begin
          $error("entropy_bits expected %0d actual %0d", e.entropy, entropy_bits_o);
          errors++;
        end
        if (byte_count_o !== e.count) begin
          $error("byte_count expected %0d actual %0d", e.count, byte_count_o);
          errors++;
        end
        if (overflowed_o !== e.ovf) begin
          $error("overflowed expected %0d actual %0d", e.ovf, overflowed_o);
          errors++;
        end
      end
    end
  end

  // Receiver stall: one long hold-off when requested, random gaps otherwise.
  always @(negedge clk_i) begin
    if (hold_req && !hold_taken) begin
      hold_taken = 1;
      hold_left = 2000;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1;
    end else if (out_gap > 0) begin
      out_gap--;
      out_stall_i <= 1;
    end else begin
      out_gap = gap_len();
      out_stall_i <= (out_gap > 0);
    end
  end

  task automatic add_byte(int unsigned v, bit l);
    byte_word_t w;
    w.value = v[7:0];
    w.last = l;
    pending_bytes.push_back(w);
  endtask

  task automatic add_buffer(int unsigned len, int unsigned kind);
    for (int i = 0; i < len; i++) begin
      case (kind)
        0: add_byte($urandom_range(0, 255), i == len - 1);
        1: add_byte($urandom_range(0, 3), i == len - 1);
        default: add_byte(8'hA5, i == len - 1);
      endcase
    end
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() > 0 || expected_results.size() > 0) @(posedge clk_i);
  endtask

  // Stimulus.
  initial begin
    int unsigned sent;
    foreach (bin_counts[b]) bin_counts[b] = 0;
    bytes_seen = 0;
    too_long = 0;
    in_valid_i = 0;
    byte_value_i = 0;
    last_byte_i = 0;
    out_stall_i = 0;
    rst_ni = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;

    // Directed: single bytes at the value extremes, single-valued, two values, and a short random buffer.
    add_byte(8'h00, 1);
    add_byte(8'hFF, 1);
    add_buffer(5, 2);
    add_byte(8'h00, 0);
    add_byte(8'hFF, 1);
    add_byte(8'h55, 0);
    add_byte(8'hAA, 0);
    add_byte(8'h55, 0);
    add_byte(8'hAA, 1);
    add_buffer(8, 0);
    wait_drained();

    // Random buffers; the receiver holds off for a long stretch once.
    sent = 0;
    while (sent < 1400) begin
      int unsigned len, p;
      p = $urandom_range(0, 99);
      if (p < 6) len = $urandom_range(120, 250);
      else len = $urandom_range(1, 40);
      add_buffer(len, $urandom_range(0, 2));
      sent += len;
      if (!hold_req && sent > 400) begin
        hold_req = 1;
        add_buffer(30, 0);
        add_buffer(30, 1);
        add_buffer(30, 0);
        sent += 90;
      end
      if (p > 95) wait_drained();
    end
    wait_drained();
    repeat (1200) @(posedge clk_i);
    stim_done = 1;
  end

  // Final report.
  initial begin
    wait (stim_done);
    $display("Checked %0d buffers, %0d of them longer than the count limit.",
             buffers_done, overflow_buffers);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Timeout.
  initial begin
    #60000000;
    $display("Mismatches found");
    $finish;
  end
endmodule

// ===== files.f =====
design/bee_pkg.sv
design/bee_ram.sv
design/bee_log2.sv
design/byte_entropy_estimator.sv
tb/byte_entropy_estimator_test.sv
